// ===== rtl/tlwp_pkg.sv =====
// tlwp_pkg: beat types, configuration codes and character constants
// shared by the text line wrap paginator modules; no dependencies
`default_nettype none

package tlwp_pkg;

  localparam int unsigned MAX_RESULTS = 4;

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic CFG_LINE_WIDTH_LIMIT = 1'b0;
  localparam logic CFG_LINES_PER_PAGE   = 1'b1;

  localparam logic [15:0] LINE_WIDTH_LIMIT_RESET = 16'd640;
  localparam logic [7:0]  LINES_PER_PAGE_RESET   = 8'd24;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic [7:0] glyph_width;
  } in_item_t;

  typedef struct packed {
    logic        is_page_mark;
    logic [7:0]  out_char;
    logic [23:0] page_offset;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] line_width_limit;
    logic [7:0]  lines_per_page;
  } cfg_t;

  typedef out_item_t [MAX_RESULTS-1:0] bundle_t;

endpackage

`default_nettype wire

// ===== rtl/tlwp_core.sv =====
// tlwp_core: input register, wrap and page state, and the per-item result bundle
// depends on tlwp_pkg
`default_nettype none

module tlwp_core #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tlwp_pkg::in_item_t in_data,
  input  wire tlwp_pkg::cfg_t    cfg,
  input  wire logic              ser_free,
  output logic                   load,
  output tlwp_pkg::bundle_t      bundle
);

  localparam int unsigned OB = OFFSET_BITS;

  logic               s1_valid;
  tlwp_pkg::in_item_t s1_item;
  logic               advance;

  logic [16:0]   line_width_sum, line_width_sum_next;
  logic [7:0]    line_count, line_count_next;
  logic [OB-1:0] output_count, output_count_next;
  logic [OB-1:0] break_offset, break_offset_next;
  logic [OB-1:0] last_mark, last_mark_next;
  logic          text_started, text_started_next;

  logic [3:0]    flags;
  logic [OB-1:0] mark_off;
  logic [16:0]   sum;
  logic [2:0]    n;
  tlwp_pkg::out_item_t cand [4];

  function automatic logic [23:0] to_field(input logic [OB-1:0] off);
    logic [OB+23:0] ext;
    ext = {{24{1'b0}}, off};
    return ext[23:0];
  endfunction

  always_comb begin
    text_started_next   = text_started;
    line_width_sum_next = line_width_sum;
    line_count_next     = line_count;
    output_count_next   = output_count;
    break_offset_next   = break_offset;
    last_mark_next      = last_mark;
    flags               = 4'b0000;
    mark_off            = '0;
    sum                 = line_width_sum + {9'b0, s1_item.glyph_width};

    if (!text_started) begin
      flags[0]          = 1'b1;
      last_mark_next    = '0;
      text_started_next = 1'b1;
    end

    if (s1_item.cmd == tlwp_pkg::CMD_END) begin
      flags[3]            = !text_started || (last_mark != output_count);
      mark_off            = output_count;
      text_started_next   = 1'b0;
      line_width_sum_next = '0;
      line_count_next     = '0;
      output_count_next   = '0;
      break_offset_next   = '0;
      last_mark_next      = '0;
    end else begin
      if (s1_item.char_code == tlwp_pkg::CH_LF) begin
        line_width_sum_next = '0;
        line_count_next     = line_count + 8'd1;
        flags[2]            = 1'b1;
        output_count_next   = output_count + OB'(1);
        break_offset_next   = output_count + OB'(1);
      end else if (s1_item.char_code != tlwp_pkg::CH_CR) begin
        flags[2] = 1'b1;
        if (sum > {1'b0, cfg.line_width_limit}) begin
          line_width_sum_next = {9'b0, s1_item.glyph_width};
          line_count_next     = line_count + 8'd1;
          flags[1]            = 1'b1;
          break_offset_next   = output_count + OB'(1);
          output_count_next   = output_count + OB'(2);
        end else begin
          line_width_sum_next = sum;
          output_count_next   = output_count + OB'(1);
        end
      end
      if (line_count_next >= cfg.lines_per_page) begin
        line_count_next = '0;
        flags[3]        = 1'b1;
        mark_off        = break_offset_next;
        last_mark_next  = break_offset_next;
      end
    end
  end

  // candidates in emission order: opening mark, inserted break, character, page mark
  always_comb begin
    cand[0] = '{is_page_mark: 1'b1, out_char: 8'd0, page_offset: 24'd0, last: 1'b0};
    cand[1] = '{is_page_mark: 1'b0, out_char: tlwp_pkg::CH_LF, page_offset: 24'd0,
                last: 1'b0};
    cand[2] = '{is_page_mark: 1'b0, out_char: s1_item.char_code, page_offset: 24'd0,
                last: 1'b0};
    cand[3] = '{is_page_mark: 1'b1, out_char: 8'd0, page_offset: to_field(mark_off),
                last: 1'b0};
  end

  always_comb begin
    bundle = '0;
    n      = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if (flags[k]) begin
        bundle[n[1:0]] = cand[k];
        n = n + 3'd1;
      end
    end
    if (n != 3'd0) begin
      bundle[n[1:0] - 2'd1].last = 1'b1;
    end
  end

  assign advance  = s1_valid && (ser_free || (n == 3'd0));
  assign load     = s1_valid && ser_free && (n != 3'd0);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      text_started   <= 1'b0;
      line_width_sum <= '0;
      line_count     <= '0;
      output_count   <= '0;
      break_offset   <= '0;
      last_mark      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        text_started   <= text_started_next;
        line_width_sum <= line_width_sum_next;
        line_count     <= line_count_next;
        output_count   <= output_count_next;
        break_offset   <= break_offset_next;
        last_mark      <= last_mark_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlwp_serializer.sv =====
// tlwp_serializer: result register that hands out a bundle one beat at a time
// depends on tlwp_pkg
`default_nettype none

module tlwp_serializer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire tlwp_pkg::bundle_t  bundle,
  output logic                    ser_free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tlwp_pkg::out_item_t     out_data
);

  logic              b_valid;
  tlwp_pkg::bundle_t entries;
  logic [1:0]        idx;
  logic              beat_done;

  assign out_valid = b_valid;
  assign out_data  = entries[idx];
  assign beat_done = b_valid && out_ready;
  assign ser_free  = !b_valid || (beat_done && out_data.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      idx     <= '0;
    end else if (load) begin
      b_valid <= 1'b1;
      idx     <= '0;
    end else if (beat_done) begin
      if (out_data.last) begin
        b_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= bundle;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_line_wrap_paginator_top.sv =====
// text_line_wrap_paginator_top: configuration registers, core and serializer
// depends on tlwp_pkg, tlwp_core, tlwp_serializer
//
//   channel  signals                              beat
//   in       in_valid in_ready in_data             one character or end item
//   out      out_valid out_ready out_data          one character or page mark
//   cfg      cfg_valid cfg_ready cfg_index cfg_data one register write
//
// an item passes the input register and is turned combinationally into up to four results;
// the output register then sends one result per cycle while out_ready is high
// the input register frees, and takes the next item, in the cycle the last result of the
// item ahead of it is sent; an item with no result leaves the input register at once
// reset clears the text state and the configuration to its defaults; cfg_ready stays high
// a stall on out holds the current result and, once the input register is full, in_ready low
`default_nettype none

module text_line_wrap_paginator_top #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tlwp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tlwp_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data
);

  tlwp_pkg::cfg_t    cfg;
  tlwp_pkg::bundle_t bundle;
  logic              load;
  logic              ser_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width_limit <= tlwp_pkg::LINE_WIDTH_LIMIT_RESET;
      cfg.lines_per_page   <= tlwp_pkg::LINES_PER_PAGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tlwp_pkg::CFG_LINE_WIDTH_LIMIT: cfg.line_width_limit <= cfg_data;
        tlwp_pkg::CFG_LINES_PER_PAGE:   cfg.lines_per_page   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tlwp_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .ser_free (ser_free),
    .load     (load),
    .bundle   (bundle)
  );

  tlwp_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .bundle    (bundle),
    .ser_free  (ser_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/tlwp_checker.sv =====
// tlwp_checker: port-level assertions for text_line_wrap_paginator_top, with its bind
// depends on tlwp_pkg
`default_nettype none

module tlwp_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire tlwp_pkg::out_item_t out_data
);

  // nothing is pending after reset and a new beat can be taken
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("results pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // the results of one item leave without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside the results of one item");

  a_field_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_page_mark ? (out_data.out_char == 8'd0)
                                         : (out_data.page_offset == 24'd0)))
    else $error("unused result field not zero");

endmodule

bind text_line_wrap_paginator_top tlwp_checker u_tlwp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== test/tb_text_line_wrap_paginator_top.sv =====
// testbench for text_line_wrap_paginator_top: directed and random texts, several
// register settings and idle patterns, scored against a behavioural predictor
// depends on tlwp_pkg and the text_line_wrap_paginator_top rtl
`timescale 1ns / 100ps

module tb_text_line_wrap_paginator_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 60;
  localparam int NUM_PHASES     = 6;

  class page_scoreboard;
    logic [15:0] width_limit;
    logic [7:0]  page_lines;
    logic [16:0] line_sum;
    logic [7:0]  lines_done;
    logic [23:0] out_count;
    logic [23:0] break_off;
    logic [23:0] mark_off;
    bit          started;
    tlwp_pkg::out_item_t expected_q[$];
    int          mismatches;
    int          results_seen;
    int          marks_seen;
    int          breaks_made;

    function new();
      width_limit  = tlwp_pkg::LINE_WIDTH_LIMIT_RESET;
      page_lines   = tlwp_pkg::LINES_PER_PAGE_RESET;
      mismatches   = 0;
      results_seen = 0;
      marks_seen   = 0;
      breaks_made  = 0;
      clear_text();
    endfunction

    function void clear_text();
      line_sum   = '0;
      lines_done = '0;
      out_count  = '0;
      break_off  = '0;
      mark_off   = '0;
      started    = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [15:0] value);
      if (idx == tlwp_pkg::CFG_LINE_WIDTH_LIMIT) width_limit = value;
      else page_lines = value[7:0];
    endfunction

    function void push_char(logic [7:0] c);
      tlwp_pkg::out_item_t r;
      r = '{is_page_mark: 1'b0, out_char: c, page_offset: 24'd0, last: 1'b0};
      expected_q.push_back(r);
      out_count = out_count + 24'd1;
    endfunction

    function void push_mark(logic [23:0] off);
      tlwp_pkg::out_item_t r;
      r = '{is_page_mark: 1'b1, out_char: 8'd0, page_offset: off, last: 1'b0};
      expected_q.push_back(r);
    endfunction

    function void note_item(tlwp_pkg::in_item_t it);
      int                  first;
      bit                  was_empty;
      tlwp_pkg::out_item_t tail;
      first     = expected_q.size();
      was_empty = !started;
      if (!started) begin
        push_mark(24'd0);
        mark_off = '0;
        started  = 1'b1;
      end
      if (it.cmd == tlwp_pkg::CMD_END) begin
        if (was_empty || mark_off != out_count) push_mark(out_count);
        clear_text();
      end else begin
        if (it.char_code == tlwp_pkg::CH_LF) begin
          line_sum   = '0;
          lines_done = lines_done + 8'd1;
          push_char(tlwp_pkg::CH_LF);
          break_off  = out_count;
        end else if (it.char_code != tlwp_pkg::CH_CR) begin
          line_sum = line_sum + 17'(it.glyph_width);
          if (line_sum > 17'(width_limit)) begin
            line_sum   = 17'(it.glyph_width);
            lines_done = lines_done + 8'd1;
            push_char(tlwp_pkg::CH_LF);
            break_off  = out_count;
            breaks_made++;
          end
          push_char(it.char_code);
        end
        if (lines_done >= page_lines) begin
          lines_done = '0;
          push_mark(break_off);
          mark_off = break_off;
        end
      end
      if (expected_q.size() > first) begin
        tail = expected_q.pop_back();
        tail.last = 1'b1;
        expected_q.push_back(tail);
      end
    endfunction

    function void check_result(tlwp_pkg::out_item_t got);
      tlwp_pkg::out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (want.is_page_mark) marks_seen++;
      if (got.is_page_mark !== want.is_page_mark) begin
        $error("is_page_mark: expected %0d, got %0d", want.is_page_mark, got.is_page_mark);
        mismatches++;
      end
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %0d, got %0d", want.out_char, got.out_char);
        mismatches++;
      end
      if (got.page_offset !== want.page_offset) begin
        $error("page_offset: expected %0d, got %0d", want.page_offset, got.page_offset);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  tlwp_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  tlwp_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [15:0]         cfg_data;

  page_scoreboard sb = new();

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_reqs       = 0;
  int items_sent      = 0;
  int cfg_writes      = 0;

  text_line_wrap_paginator_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic tlwp_pkg::in_item_t make_item(logic cmd, logic [7:0] c, logic [7:0] w);
    return '{cmd: cmd, char_code: c, glyph_width: w};
  endfunction

  function automatic tlwp_pkg::in_item_t random_char();
    int          r;
    logic [7:0]  c;
    logic [7:0]  w;
    r = $urandom_range(99);
    if (r < 12) c = tlwp_pkg::CH_LF;
    else if (r < 18) c = tlwp_pkg::CH_CR;
    else c = 8'($urandom_range(255));
    if ($urandom_range(1) == 0) w = 8'($urandom_range(255));
    else w = 8'($urandom_range(40));
    return make_item(tlwp_pkg::CMD_CHAR, c, w);
  endfunction

  task automatic send_item(tlwp_pkg::in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_end();
    send_item(make_item(tlwp_pkg::CMD_END, 8'($urandom_range(255)),
                        8'($urandom_range(255))));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_page_format(logic [15:0] limit, logic [7:0] lines);
    write_reg(tlwp_pkg::CFG_LINE_WIDTH_LIMIT, limit);
    write_reg(tlwp_pkg::CFG_LINES_PER_PAGE, {8'($urandom_range(255)), lines});
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int phase_start;
    int r;
    int len;
    bit mid_done;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= tlwp_pkg::CFG_LINE_WIDTH_LIMIT;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset format: empty text, carriage-return-only text, forced break
    send_item(make_item(tlwp_pkg::CMD_END, 8'hFF, 8'hFF));
    send_item(make_item(tlwp_pkg::CMD_CHAR, tlwp_pkg::CH_CR, 8'hFF));
    send_item(make_item(tlwp_pkg::CMD_CHAR, tlwp_pkg::CH_CR, 8'h00));
    send_item(make_item(tlwp_pkg::CMD_END, 8'h00, 8'h00));
    send_item(make_item(tlwp_pkg::CMD_CHAR, 8'h00, 8'h00));
    send_item(make_item(tlwp_pkg::CMD_CHAR, 8'hFF, 8'hFF));
    send_item(make_item(tlwp_pkg::CMD_CHAR, tlwp_pkg::CH_LF, 8'h80));
    send_item(make_item(tlwp_pkg::CMD_CHAR, 8'h55, 8'hFF));
    send_item(make_item(tlwp_pkg::CMD_CHAR, 8'hAA, 8'hFF));
    send_item(make_item(tlwp_pkg::CMD_CHAR, 8'h41, 8'hFF));
    send_item(make_item(tlwp_pkg::CMD_END, 8'h00, 8'h00));

    // zero width limit and zero lines per page
    set_page_format(16'd0, 8'd0);
    send_item(make_item(tlwp_pkg::CMD_CHAR, 8'h61, 8'h00));
    send_item(make_item(tlwp_pkg::CMD_CHAR, 8'h62, 8'h01));
    send_item(make_item(tlwp_pkg::CMD_CHAR, tlwp_pkg::CH_LF, 8'h00));
    send_item(make_item(tlwp_pkg::CMD_CHAR, tlwp_pkg::CH_CR, 8'h00));
    send_item(make_item(tlwp_pkg::CMD_END, 8'hFF, 8'h00));

    // widest limit, one line per page
    set_page_format(16'hFFFF, 8'd1);
    send_item(make_item(tlwp_pkg::CMD_CHAR, 8'h7F, 8'hFF));
    send_item(make_item(tlwp_pkg::CMD_CHAR, 8'h80, 8'hFF));
    send_item(make_item(tlwp_pkg::CMD_CHAR, tlwp_pkg::CH_LF, 8'hFF));
    send_item(make_item(tlwp_pkg::CMD_CHAR, 8'h20, 8'h00));
    send_item(make_item(tlwp_pkg::CMD_END, 8'h00, 8'hFF));

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_page_format(16'd200, 8'd3);
        1: set_page_format(16'hFFFF, 8'hFF);
        2: set_page_format(16'd0, 8'd1);
        3: set_page_format(16'($urandom_range(800, 40)), 8'($urandom_range(12, 1)));
        4: set_page_format(16'd1000, 8'd0);
        default: set_page_format(16'($urandom_range(400, 100)), 8'($urandom_range(6, 2)));
      endcase
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin sender_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      phase_start = items_sent;
      mid_done    = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (!mid_done && (items_sent - phase_start >= PHASE_ITEMS / 2)) begin
          mid_done = 1'b1;
          if (p == 0 || p == 4) hold_reqs++;
          else wait_drain();
        end
        r = $urandom_range(99);
        if (r < 8) begin
          send_end();
        end else begin
          len = $urandom_range(30);
          for (int i = 0; i < len; i++) send_item(random_char());
          // now and then a text runs on without its end beat
          if (r >= 18) send_end();
        end
      end
    end

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    wait_drain();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.mismatches++;
    end
    $display("covered %0d input beats and %0d result beats over %0d register writes",
             items_sent, sb.results_seen, cfg_writes);
    $display("of those, %0d page marks and %0d inserted line breaks",
             sb.marks_seen, sb.breaks_made);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
